[hw/rtl/date_day_offset_adder_top_macros.svh]
// Assertion helpers shared by the date offset adder RTL.
// Each helper needs clk_i and rst_ni in scope.
`ifndef DATE_DAY_OFFSET_ADDER_TOP_MACROS_SVH
`define DATE_DAY_OFFSET_ADDER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dda_pkg.sv]
`default_nettype none

package dda_pkg;

  // Field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int OFF_W   = 16;

  // Accepted year range, both bounds exclusive
  localparam logic [YEAR_W-1:0] MIN_YEAR_EXCL = YEAR_W'(1800);
  localparam logic [YEAR_W-1:0] MAX_YEAR_EXCL = YEAR_W'(2300);

  // Month codes
  localparam logic [MONTH_W-1:0] MON_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MON_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MON_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MON_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MON_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MON_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MON_DEC = MONTH_W'(12);

  // Month lengths
  localparam logic [DAY_W-1:0] LEN_28 = DAY_W'(28);
  localparam logic [DAY_W-1:0] LEN_29 = DAY_W'(29);
  localparam logic [DAY_W-1:0] LEN_30 = DAY_W'(30);
  localparam logic [DAY_W-1:0] LEN_31 = DAY_W'(31);

  // Number of centuries representable in a year field
  localparam int CENT_CNT = ((1 << YEAR_W) - 1) / 100;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture a new request
    logic step;    // advance one month
    logic finish;  // write the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cont;    // more months to cross
  } status_t;

  // Year is a multiple of 100: compare against every century
  function automatic logic is_century(input logic [YEAR_W-1:0] y);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k <= CENT_CNT; k++) begin
      if (y == YEAR_W'(k * 100)) hit = 1'b1;
    end
    return hit;
  endfunction

  // Gregorian rule; a century is a leap year only when also divisible by 16
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (!is_century(y) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y);
    logic [DAY_W-1:0] len;
    case (m) inside
      MON_FEB:                          len = is_leap(y) ? LEN_29 : LEN_28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
      default:                          len = LEN_31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dda_dpath.sv]
`default_nettype none

module dda_dpath (
  input  wire                           clk_i,
  input  dda_pkg::cmd_t                 cmd_i,
  output dda_pkg::status_t              status_o,
  input  wire  [dda_pkg::DAY_W-1:0]     in_day_i,
  input  wire  [dda_pkg::MONTH_W-1:0]   in_month_i,
  input  wire  [dda_pkg::YEAR_W-1:0]    in_year_i,
  input  wire  signed [dda_pkg::OFF_W-1:0] day_offset_i,
  output logic [dda_pkg::DAY_W-1:0]     out_day_o,
  output logic [dda_pkg::MONTH_W-1:0]   out_month_o,
  output logic [dda_pkg::YEAR_W-1:0]    out_year_o,
  output logic                          date_valid_o
);

  localparam int DAY_W   = dda_pkg::DAY_W;
  localparam int MONTH_W = dda_pkg::MONTH_W;
  localparam int YEAR_W  = dda_pkg::YEAR_W;
  localparam int OFF_W   = dda_pkg::OFF_W;

  // Working date, remaining offset magnitude and direction
  logic [DAY_W-1:0]   d_q;
  logic [MONTH_W-1:0] m_q;
  logic [YEAR_W-1:0]  y_q;
  logic [OFF_W-1:0]   mag_q;
  logic               back_q;
  logic               ok_q;

  // Result register
  logic [DAY_W-1:0]   res_day_q;
  logic [MONTH_W-1:0] res_month_q;
  logic [YEAR_W-1:0]  res_year_q;
  logic               res_ok_q;

  logic               in_ok;
  logic [OFF_W-1:0]   off_u;
  logic [OFF_W-1:0]   in_mag;
  logic [DAY_W-1:0]   len_cur;
  logic [DAY_W-1:0]   room;
  logic [MONTH_W-1:0] m_next;
  logic [YEAR_W-1:0]  y_next;
  logic [MONTH_W-1:0] m_prev;
  logic [YEAR_W-1:0]  y_prev;
  logic [DAY_W-1:0]   len_prev;
  logic [DAY_W-1:0]   d_final;

  // Starting date check
  always_comb begin
    in_ok = (in_year_i > dda_pkg::MIN_YEAR_EXCL) && (in_year_i < dda_pkg::MAX_YEAR_EXCL) &&
            (in_month_i >= dda_pkg::MON_JAN) && (in_month_i <= dda_pkg::MON_DEC) &&
            (in_day_i != '0) &&
            (in_day_i <= dda_pkg::month_len(in_month_i, in_year_i));
  end

  // Offset magnitude; the most negative offset maps to 2^(OFF_W-1)
  assign off_u  = OFF_W'(day_offset_i);
  assign in_mag = day_offset_i[OFF_W-1] ? OFF_W'(~off_u + 1'b1) : off_u;

  // Neighbor months
  always_comb begin
    len_cur = dda_pkg::month_len(m_q, y_q);
    room    = len_cur - d_q;
    if (m_q == dda_pkg::MON_DEC) begin
      m_next = dda_pkg::MON_JAN;
      y_next = y_q + 1'b1;
    end else begin
      m_next = m_q + 1'b1;
      y_next = y_q;
    end
    if (m_q == dda_pkg::MON_JAN) begin
      m_prev = dda_pkg::MON_DEC;
      y_prev = y_q - 1'b1;
    end else begin
      m_prev = m_q - 1'b1;
      y_prev = y_q;
    end
    len_prev = dda_pkg::month_len(m_prev, y_prev);
  end

  // Another month must be crossed while the offset leaves the current month
  always_comb begin
    if (back_q) begin
      status_o.cont = ok_q && (mag_q >= OFF_W'(d_q));
    end else begin
      status_o.cont = ok_q && (mag_q > OFF_W'(room));
    end
  end

  // Offset now lands inside the current month
  assign d_final = back_q ? (d_q - mag_q[DAY_W-1:0]) : (d_q + mag_q[DAY_W-1:0]);

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_q    <= in_day_i;
      m_q    <= in_month_i;
      y_q    <= in_year_i;
      mag_q  <= in_mag;
      back_q <= day_offset_i[OFF_W-1];
      ok_q   <= in_ok;
    end else if (cmd_i.step) begin
      if (back_q) begin
        mag_q <= mag_q - OFF_W'(d_q);
        m_q   <= m_prev;
        y_q   <= y_prev;
        d_q   <= len_prev;
      end else begin
        mag_q <= mag_q - OFF_W'(room) - 1'b1;
        m_q   <= m_next;
        y_q   <= y_next;
        d_q   <= DAY_W'(1);
      end
    end
  end

  // Result register; zeros for a rejected date
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_day_q   <= ok_q ? d_final : '0;
      res_month_q <= ok_q ? m_q : '0;
      res_year_q  <= ok_q ? y_q : '0;
      res_ok_q    <= ok_q;
    end
  end

  assign out_day_o    = res_day_q;
  assign out_month_o  = res_month_q;
  assign out_year_o   = res_year_q;
  assign date_valid_o = res_ok_q;

endmodule

`default_nettype wire

[hw/rtl/dda_ctrl.sv]
`default_nettype none

`include "date_day_offset_adder_top_macros.svh"

module dda_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output dda_pkg::cmd_t     cmd_o,
  input  dda_pkg::status_t  status_i
);

  dda_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  // Result register can take a new result this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dda_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.step   = 1'b0;
    cmd_o.finish = 1'b0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      dda_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = dda_pkg::ST_RUN;
        end
      end
      dda_pkg::ST_RUN: begin
        if (status_i.cont) begin
          cmd_o.step = 1'b1;
        end else if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = dda_pkg::ST_IDLE;
        end
      end
      default: state_d = dda_pkg::ST_IDLE;
    endcase
  end

  // Result valid: set on finish, cleared when the result is taken
  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `DDA_ASSERT_NEXT(a_finish_shows, cmd_o.finish, out_valid_o, "finish did not present a result")
  `DDA_ASSERT_SAME(a_finish_done, cmd_o.finish, !status_i.cont && slot_free, "finish too early")
  `DDA_ASSERT_SAME(a_busy_stalls, state_q == dda_pkg::ST_RUN, in_stall_o, "request taken while busy")
  `DDA_ASSERT_SAME(a_run_entry, (state_q == dda_pkg::ST_RUN) && ($past(state_q) == dda_pkg::ST_IDLE),
                   $past(in_valid_i), "run entered without a request")

endmodule

`default_nettype wire

[hw/rtl/date_day_offset_adder_top.sv]
// Requests are accepted only in idle; a new request is stalled until the current one is finished.
// The month stepper crosses one month a cycle, up to about 1080 months for the largest offset;
//   the result register is written once no month remains and the output slot is free.
// A finished result waits in its own register while the next request is accepted.
// Reset (rst_ni, asynchronous, active low) returns to idle with no result pending.
`default_nettype none

module date_day_offset_adder_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [dda_pkg::DAY_W-1:0]        in_day_i,
  input  wire  [dda_pkg::MONTH_W-1:0]      in_month_i,
  input  wire  [dda_pkg::YEAR_W-1:0]       in_year_i,
  input  wire  signed [dda_pkg::OFF_W-1:0] day_offset_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [dda_pkg::DAY_W-1:0]        out_day_o,
  output logic [dda_pkg::MONTH_W-1:0]      out_month_o,
  output logic [dda_pkg::YEAR_W-1:0]       out_year_o,
  output logic                             date_valid_o
);

  dda_pkg::cmd_t    cmd;
  dda_pkg::status_t status;

  // Sequencer
  dda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Date check and month stepper
  dda_dpath u_dpath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_day_i     (in_day_i),
    .in_month_i   (in_month_i),
    .in_year_i    (in_year_i),
    .day_offset_i (day_offset_i),
    .out_day_o    (out_day_o),
    .out_month_o  (out_month_o),
    .out_year_o   (out_year_o),
    .date_valid_o (date_valid_o)
  );

endmodule

`default_nettype wire
